@@ src/ptlct_pkg.sv @@
// ptlct_pkg: shared types, constants and helpers for the parent-to-local transform.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ptlct_pkg;

	localparam int TRIG_STEPS = 16;
	localparam int DIV_BITS   = 34;
	localparam int PIPE_DEPTH = TRIG_STEPS + DIV_BITS + 7;

	localparam logic signed [17:0] FULL_TURN    = 18'sd23040;
	localparam logic signed [17:0] HALF_TURN    = 18'sd11520;
	localparam logic signed [17:0] QUARTER_TURN = 18'sd5760;
	localparam logic signed [32:0] GAIN_INV     = 33'sd652032874;
	localparam logic signed [32:0] ONE_Q30      = 33'sd1073741824;

	localparam logic [2:0] REG_POS_X = 3'd0;
	localparam logic [2:0] REG_POS_Y = 3'd1;
	localparam logic [2:0] REG_PIV_X = 3'd2;
	localparam logic [2:0] REG_PIV_Y = 3'd3;
	localparam logic [2:0] REG_SCL_X = 3'd4;
	localparam logic [2:0] REG_SCL_Y = 3'd5;
	localparam logic [2:0] REG_ROT   = 3'd6;

	localparam logic [1:0] SP_NONE  = 2'd0;
	localparam logic [1:0] SP_ZERO  = 2'd1;
	localparam logic [1:0] SP_POS90 = 2'd2;
	localparam logic [1:0] SP_NEG90 = 2'd3;

	typedef logic signed [34:0] off_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [25:0] z;
		logic [1:0]         spec;
		logic               flip;
		off_t               tox;
		off_t               toy;
	} cordic_t;

	typedef struct packed {
		logic        neg;
		logic        big;
		logic [69:0] rem;
		logic [33:0] quo;
	} div_t;

	// arctangent of 2^-i in units of 2^-16 degree
	function automatic logic signed [25:0] atan_lut(input logic [4:0] i);
		logic signed [25:0] v;
		unique case (i)
			5'd0:  v = 26'sd2949120;
			5'd1:  v = 26'sd1740967;
			5'd2:  v = 26'sd919879;
			5'd3:  v = 26'sd466945;
			5'd4:  v = 26'sd234379;
			5'd5:  v = 26'sd117304;
			5'd6:  v = 26'sd58666;
			5'd7:  v = 26'sd29335;
			5'd8:  v = 26'sd14668;
			5'd9:  v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

	// sign, pivot add, zero-scale clear and saturation of one axis
	function automatic logic [31:0] finish_axis(input div_t d, input logic signed [31:0] piv,
		input logic zero);
		logic signed [35:0] qs;
		logic signed [36:0] sum;
		logic [31:0]        r;
		qs  = d.neg ? -$signed({2'b00, d.quo}) : $signed({2'b00, d.quo});
		sum = 37'(qs) + 37'(piv);
		if (zero)
			r = 32'h0000_0000;
		else if (d.big)
			r = d.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else if (sum > 37'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (sum < -37'sd2147483648)
			r = 32'h8000_0000;
		else
			r = sum[31:0];
		return r;
	endfunction

endpackage

@@ src/ptlct_cordic_cell.sv @@
// ptlct_cordic_cell: one registered CORDIC rotation step, passes offsets along.
// Depends on ptlct_pkg.
`timescale 1ns / 1ps
module ptlct_cordic_cell
	import ptlct_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  logic [4:0] step,
	input  cordic_t    data,
	output cordic_t    result
);

	cordic_t nxt;
	cordic_t res_q;

	always_comb begin
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		dx  = data.y >>> step;
		dy  = data.x >>> step;
		nxt = data;
		if (!data.z[25]) begin
			nxt.x = data.x - dx;
			nxt.y = data.y + dy;
			nxt.z = data.z - atan_lut(step);
		end else begin
			nxt.x = data.x + dx;
			nxt.y = data.y - dy;
			nxt.z = data.z + atan_lut(step);
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= nxt;
	end

	assign result = res_q;

endmodule

@@ src/ptlct_div_cell.sv @@
// ptlct_div_cell: one registered restoring-division step, one quotient bit.
// Depends on ptlct_pkg.
`timescale 1ns / 1ps
module ptlct_div_cell
	import ptlct_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [5:0]  step,
	input  logic [33:0] divisor,
	input  div_t        data,
	output div_t        result
);

	div_t nxt;
	div_t res_q;

	always_comb begin
		logic [69:0] sh;
		sh  = {36'd0, divisor} << step;
		nxt = data;
		if (data.rem >= sh) begin
			nxt.rem = data.rem - sh;
			nxt.quo = data.quo | (34'd1 << step);
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= nxt;
	end

	assign result = res_q;

endmodule

@@ src/parent_to_local_coordinate_transform_unit.sv @@
// parent_to_local_coordinate_transform_unit: top level, config registers and pipeline.
// Depends on ptlct_pkg, ptlct_cordic_cell, ptlct_div_cell.
//
//  channel | signals                                 | direction
//  in      | in_valid, in_stall, parent_x, parent_y  | request in
//  out     | out_valid, out_stall, local_x/y, fault  | request out
//  cfg     | cfg_we, cfg_idx, cfg_data               | write only
//
// One request per cycle while not stalled; pipeline stages: prep, 16 CORDIC cells, trig round,
// products, sums, magnitude, rounding bias, 34 divider cells per axis, output register.
// Reset clears the valid line and sets the config registers to their defaults.
// A stalled result holds the whole line; in_stall follows out_stall then.
`timescale 1ns / 1ps
module parent_to_local_coordinate_transform_unit
	import ptlct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] parent_x,
	input  logic signed [31:0] parent_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] local_x,
	output logic signed [31:0] local_y,
	output logic               scale_fault,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);

	logic signed [31:0] pos_x_q, pos_y_q, piv_x_q, piv_y_q;
	logic [23:0]        scl_x_q, scl_y_q;
	logic signed [15:0] rot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			piv_x_q <= '0;
			piv_y_q <= '0;
			scl_x_q <= 24'd65536;
			scl_y_q <= 24'd65536;
			rot_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POS_X: pos_x_q <= cfg_data;
				REG_POS_Y: pos_y_q <= cfg_data;
				REG_PIV_X: piv_x_q <= cfg_data;
				REG_PIV_Y: piv_y_q <= cfg_data;
				REG_SCL_X: scl_x_q <= cfg_data[23:0];
				REG_SCL_Y: scl_y_q <= cfg_data[23:0];
				REG_ROT:   rot_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en        = !(vld_q[PIPE_DEPTH-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
	end

	// angle reduction, fold, special-angle detection and offsets
	cordic_t prep;

	always_comb begin
		logic signed [17:0] a;
		a = 18'(rot_q);
		if (a < 0)
			a = a + FULL_TURN;
		if (a < 0)
			a = a + FULL_TURN;
		if (a >= FULL_TURN)
			a = a - FULL_TURN;
		if (a > HALF_TURN)
			a = a - FULL_TURN;
		prep.flip = 1'b0;
		if (a > QUARTER_TURN) begin
			a = a - HALF_TURN;
			prep.flip = 1'b1;
		end else if (a < -QUARTER_TURN) begin
			a = a + HALF_TURN;
			prep.flip = 1'b1;
		end
		priority if (a == 18'sd0)
			prep.spec = SP_ZERO;
		else if (a == QUARTER_TURN)
			prep.spec = SP_POS90;
		else if (a == -QUARTER_TURN)
			prep.spec = SP_NEG90;
		else
			prep.spec = SP_NONE;
		prep.x   = GAIN_INV;
		prep.y   = '0;
		prep.z   = {a[15:0], 10'd0};
		prep.tox = 35'(parent_x) - 35'(pos_x_q) - 35'(piv_x_q);
		prep.toy = 35'(parent_y) - 35'(pos_y_q) - 35'(piv_y_q);
	end

	cordic_t cc [0:TRIG_STEPS];

	always_ff @(posedge clk) begin
		if (en)
			cc[0] <= prep;
	end

	for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_cordic
		ptlct_cordic_cell u_cell (
			.clk    (clk),
			.en     (en),
			.step   (5'(k)),
			.data   (cc[k]),
			.result (cc[k+1])
		);
	end

	// special-angle substitution, flip and trig rounding to Q26
	logic signed [28:0] cos_s1, sin_s1;
	off_t               tox_s1, toy_s1;

	always_ff @(posedge clk) begin
		logic signed [32:0] cx, cy;
		unique case (cc[TRIG_STEPS].spec)
			SP_ZERO:  begin cx = ONE_Q30; cy = '0;       end
			SP_POS90: begin cx = '0;      cy = ONE_Q30;  end
			SP_NEG90: begin cx = '0;      cy = -ONE_Q30; end
			default:  begin cx = cc[TRIG_STEPS].x; cy = cc[TRIG_STEPS].y; end
		endcase
		if (cc[TRIG_STEPS].flip) begin
			cx = -cx;
			cy = -cy;
		end
		if (en) begin
			cos_s1 <= 29'((cx + 33'sd8) >>> 4);
			sin_s1 <= 29'((cy + 33'sd8) >>> 4);
			tox_s1 <= cc[TRIG_STEPS].tox;
			toy_s1 <= cc[TRIG_STEPS].toy;
		end
	end

	logic signed [63:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [63:0] rx_s3, ry_s3;
	logic               nx_s4, ny_s4;
	logic [62:0]        mx_s4, my_s4;
	logic [33:0]        dvx, dvy;

	assign dvx = {scl_x_q, 10'd0};
	assign dvy = {scl_y_q, 10'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			pxc_s2 <= 64'(tox_s1) * 64'(cos_s1);
			pys_s2 <= 64'(toy_s1) * 64'(sin_s1);
			pyc_s2 <= 64'(toy_s1) * 64'(cos_s1);
			pxs_s2 <= 64'(tox_s1) * 64'(sin_s1);
			rx_s3  <= pxc_s2 + pys_s2;
			ry_s3  <= pyc_s2 - pxs_s2;
			nx_s4  <= rx_s3[63];
			ny_s4  <= ry_s3[63];
			mx_s4  <= rx_s3[63] ? 63'(-rx_s3) : 63'(rx_s3);
			my_s4  <= ry_s3[63] ? 63'(-ry_s3) : 63'(ry_s3);
		end
	end

	div_t dx_c [0:DIV_BITS];
	div_t dy_c [0:DIV_BITS];

	always_ff @(posedge clk) begin
		logic [69:0] numx, numy;
		numx = 70'(mx_s4) + 70'(dvx >> 1);
		numy = 70'(my_s4) + 70'(dvy >> 1);
		if (en) begin
			dx_c[0] <= '{neg: nx_s4, big: (numx >= {2'b00, dvx, 34'd0}), rem: numx, quo: '0};
			dy_c[0] <= '{neg: ny_s4, big: (numy >= {2'b00, dvy, 34'd0}), rem: numy, quo: '0};
		end
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		ptlct_div_cell u_dx (
			.clk     (clk),
			.en      (en),
			.step    (6'(DIV_BITS - 1 - k)),
			.divisor (dvx),
			.data    (dx_c[k]),
			.result  (dx_c[k+1])
		);
		ptlct_div_cell u_dy (
			.clk     (clk),
			.en      (en),
			.step    (6'(DIV_BITS - 1 - k)),
			.divisor (dvy),
			.data    (dy_c[k]),
			.result  (dy_c[k+1])
		);
	end

	logic zx, zy;
	assign zx = (scl_x_q == 24'd0);
	assign zy = (scl_y_q == 24'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			local_x     <= finish_axis(dx_c[DIV_BITS], piv_x_q, zx);
			local_y     <= finish_axis(dy_c[DIV_BITS], piv_y_q, zy);
			scale_fault <= zx || zy;
		end
	end

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scale_fault == ((scl_x_q == 24'd0) || (scl_y_q == 24'd0))))
		else $error("scale_fault disagrees with scale registers");

	a_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scl_x_q == 24'd0) |-> (local_x == 32'sd0))
		else $error("local_x not cleared on zero scale");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(vld_q))
		else $error("pipeline moved during output stall");

endmodule
